// ===== rtl/lmsa_pkg.sv =====
// Package for the layer mode share arbiter: operation and status codes,
// mode codes and the state record shared by the core and the top level.
// Depends on nothing.
package lmsa_pkg;

    localparam int MAX_LAYERS = 8;
    localparam int ID_W       = $clog2(MAX_LAYERS);
    localparam int COUNT_W    = 8;
    localparam int CFG_W      = 4;

    localparam logic [CFG_W-1:0] LAYER_COUNT_RESET = CFG_W'(6);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [MAX_LAYERS-1:0] layer_mask_t;

    typedef enum logic [2:0] {
        OP_REGISTER   = 3'd0,
        OP_UNREGISTER = 3'd1,
        OP_ENABLE     = 3'd2,
        OP_DISABLE    = 3'd3,
        OP_ACQUIRE    = 3'd4,
        OP_RELEASE    = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_NOT_REG  = 3'd2,
        ST_ALREADY  = 3'd3,
        ST_WAIT     = 3'd4,
        ST_MISMATCH = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MODE_DISPLAY = 2'd0,
        MODE_CAPTURE = 2'd1,
        MODE_NONE    = 2'd2
    } mode_t;

    // Arbiter state as held in the top level and updated by the core.
    typedef struct packed {
        layer_mask_t          registered;
        layer_mask_t          enabled;
        layer_mask_t          waiting;
        layer_mask_t          mode;
        layer_mask_t          hw_enable;
        logic [COUNT_W-1:0]   users;
        logic [1:0]           running_mode;
    } arb_state_t;

    // Result of one transaction.
    typedef struct packed {
        logic [2:0]   status;
        layer_mask_t  wake;
    } arb_result_t;

endpackage

// ===== rtl/layer_mode_share_arbiter_unit.sv =====
// Top level of the layer mode share arbiter: state registers, result
// register and APB configuration port. Depends on lmsa_pkg and lmsa_core.
//
// The arbiter takes one transaction in every clock cycle: busy is always
// low, and the result of a transaction accepted at one edge is on the
// result ports, marked by done, for the single following cycle. The state
// update and the result are one pass of logic from the command ports and
// the state registers into the state and result registers. The receiver
// cannot stall; a result not taken in its cycle is gone. layer_count is
// written at byte address 0 and must only be changed while no transaction
// is in flight.
module layer_mode_share_arbiter_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    opcode,
    input  logic [lmsa_pkg::ID_W-1:0]     layer_id,
    input  logic                          register_mode,

    output logic                          done,
    output logic [2:0]                    status,
    output logic [7:0]                    layer_enable_mask,
    output logic [7:0]                    wake_mask,
    output logic [7:0]                    active_users,
    output logic [1:0]                    current_mode,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int MW = lmsa_pkg::MAX_LAYERS;

    lmsa_pkg::arb_state_t  state_reg;
    lmsa_pkg::arb_state_t  state_next;
    lmsa_pkg::arb_result_t result;
    lmsa_pkg::layer_mask_t lanes;

    logic [lmsa_pkg::CFG_W-1:0] layer_count_reg;
    logic                       done_reg;
    logic [2:0]                 status_reg;
    lmsa_pkg::layer_mask_t      wake_reg;
    logic                       accept;
    logic                       cfg_write;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

    // A lane is in use when its id lies below layer_count.
    always_comb
    begin
        for (int i = 0; i < MW; i++)
        begin
            lanes[i] = layer_count_reg > lmsa_pkg::CFG_W'(i);
        end
    end

    lmsa_core u_core
    (
        .state         (state_reg),
        .lanes         (lanes),
        .opcode        (opcode),
        .layer_id      (layer_id),
        .register_mode (register_mode),
        .state_next    (state_next),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg        <= lmsa_pkg::LAYER_COUNT_RESET;
            state_reg.registered   <= '0;
            state_reg.enabled      <= '0;
            state_reg.waiting      <= '0;
            state_reg.mode         <= '0;
            state_reg.hw_enable    <= '0;
            state_reg.users        <= '0;
            state_reg.running_mode <= lmsa_pkg::MODE_NONE;
            done_reg               <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_write)
            begin
                layer_count_reg <= pwdata[lmsa_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= result.status;
            wake_reg   <= result.wake;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (!paddr[2])
        begin
            prdata[lmsa_pkg::CFG_W-1:0] = layer_count_reg;
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign layer_enable_mask = 8'(state_reg.hw_enable);
    assign wake_mask         = 8'(wake_reg);
    assign active_users      = state_reg.users;
    assign current_mode      = state_reg.running_mode;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept))
        else $error("done does not follow an accepted transaction");

    a_wake_only_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && wake_mask != '0) |-> (active_users == '0 && status == lmsa_pkg::ST_OK))
        else $error("layers woken while users remain");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(accept) |-> ($stable(state_reg.users) && $stable(state_reg.hw_enable)
                            && $stable(state_reg.running_mode)))
        else $error("arbiter state changed without a transaction");

    a_wait_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == lmsa_pkg::ST_WAIT) |-> $stable(state_reg.users))
        else $error("a waiting acquire changed the user count");

    a_mode_set_with_users: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.users != '0) |-> (state_reg.running_mode != lmsa_pkg::MODE_NONE))
        else $error("users counted with no running mode");

endmodule

// ===== rtl/lmsa_core.sv =====
// Combinational next-state and result logic for one transaction of the
// layer mode share arbiter. Depends on lmsa_pkg.
module lmsa_core
(
    input  lmsa_pkg::arb_state_t          state,
    input  lmsa_pkg::layer_mask_t         lanes,
    input  logic [2:0]                    opcode,
    input  logic [lmsa_pkg::ID_W-1:0]     layer_id,
    input  logic                          register_mode,
    output lmsa_pkg::arb_state_t          state_next,
    output lmsa_pkg::arb_result_t         result
);

    lmsa_pkg::layer_mask_t bit_sel;
    lmsa_pkg::layer_mask_t sel;
    lmsa_pkg::layer_mask_t same;
    lmsa_pkg::layer_mask_t wake_set;
    logic                  id_valid;
    logic                  is_reg;
    logic                  lmode;
    logic                  mode_differs;
    logic [lmsa_pkg::COUNT_W-1:0] users_dec;

    always_comb
    begin
        bit_sel      = lmsa_pkg::layer_mask_t'(1) << layer_id;
        id_valid     = |(lanes & bit_sel);
        is_reg       = |(state.registered & bit_sel);
        lmode        = state.mode[layer_id];
        mode_differs = state.running_mode != {1'b0, lmode};
        sel          = state.registered & lanes;
        same         = lmode ? state.mode : ~state.mode;
        users_dec    = (state.users != '0) ? state.users - 1'b1 : state.users;
        wake_set     = state.waiting & lanes;

        state_next    = state;
        result.status = lmsa_pkg::ST_OK;
        result.wake   = '0;

        if (opcode <= 3'(lmsa_pkg::OP_RELEASE) && !id_valid)
        begin
            result.status = lmsa_pkg::ST_INVALID;
        end
        else
        begin
            case (opcode)
                lmsa_pkg::OP_REGISTER:
                begin
                    if (is_reg)
                    begin
                        result.status = lmsa_pkg::ST_ALREADY;
                    end
                    else
                    begin
                        state_next.registered = state.registered | bit_sel;
                        state_next.mode = (state.mode & ~bit_sel)
                                        | ({lmsa_pkg::MAX_LAYERS{register_mode}} & bit_sel);
                    end
                end
                lmsa_pkg::OP_UNREGISTER,
                lmsa_pkg::OP_ENABLE,
                lmsa_pkg::OP_DISABLE,
                lmsa_pkg::OP_ACQUIRE:
                begin
                    if (!is_reg)
                    begin
                        result.status = lmsa_pkg::ST_NOT_REG;
                    end
                    else if (opcode == lmsa_pkg::OP_UNREGISTER)
                    begin
                        state_next.registered = state.registered & ~bit_sel;
                        state_next.enabled    = state.enabled & ~bit_sel;
                        state_next.waiting    = state.waiting & ~bit_sel;
                    end
                    else if (opcode == lmsa_pkg::OP_ENABLE)
                    begin
                        state_next.enabled   = state.enabled | bit_sel;
                        state_next.hw_enable = state.hw_enable | bit_sel;
                    end
                    else if (opcode == lmsa_pkg::OP_DISABLE)
                    begin
                        state_next.enabled   = state.enabled & ~bit_sel;
                        state_next.hw_enable = state.hw_enable & ~bit_sel;
                    end
                    else if (state.users != '0 && mode_differs)
                    begin
                        state_next.waiting = state.waiting | bit_sel;
                        result.status      = lmsa_pkg::ST_WAIT;
                    end
                    else
                    begin
                        // First user in a new mode: reprogram the enables of
                        // every registered layer in use.
                        if (state.users == '0 && mode_differs)
                        begin
                            state_next.hw_enable = (state.hw_enable & ~sel)
                                                 | (sel & state.enabled & same);
                            state_next.running_mode = {1'b0, lmode};
                        end
                        if (state.users != lmsa_pkg::COUNT_MAX)
                        begin
                            state_next.users = state.users + 1'b1;
                        end
                    end
                end
                lmsa_pkg::OP_RELEASE:
                begin
                    if (mode_differs)
                    begin
                        result.status = lmsa_pkg::ST_MISMATCH;
                    end
                    else
                    begin
                        state_next.users = users_dec;
                        if (users_dec == '0)
                        begin
                            result.wake        = wake_set;
                            state_next.waiting = state.waiting & ~wake_set;
                        end
                    end
                end
                default:
                begin
                    result.status = lmsa_pkg::ST_OK;
                end
            endcase
        end
    end

endmodule
